@@ sv/direct_mapped_cache_timing_model_unit_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the direct-mapped cache timing model
// Same-cycle and next-cycle implication checks, disabled while reset is low.
// ----------------------------------------------------------------------------
`ifndef DIRECT_MAPPED_CACHE_TIMING_MODEL_UNIT_DEFINES_SVH
`define DIRECT_MAPPED_CACHE_TIMING_MODEL_UNIT_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define DMC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define DMC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/dmc_pkg.sv @@
// ----------------------------------------------------------------------------
// dmc_pkg
// Shared types and constants of the direct-mapped cache timing model.
// ----------------------------------------------------------------------------
package dmc_pkg;

    localparam int MAX_LINES = 256;
    localparam int IDX_W     = $clog2(MAX_LINES);
    localparam int TAG_BITS  = 32;

    localparam logic [2:0] REG_BLOCK_BYTES  = 3'd0;
    localparam logic [2:0] REG_LINE_COUNT   = 3'd1;
    localparam logic [2:0] REG_BUS_WIDTH    = 3'd2;
    localparam logic [2:0] REG_MEM_READ     = 3'd3;
    localparam logic [2:0] REG_MEM_WRITE    = 3'd4;
    localparam logic [2:0] REG_CACHE_READ   = 3'd5;
    localparam logic [2:0] REG_CACHE_WRITE  = 3'd6;

    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    localparam logic [1:0] OUT_HIT      = 2'd0;
    localparam logic [1:0] OUT_EMPTY    = 2'd1;
    localparam logic [1:0] OUT_MISMATCH = 2'd2;

    typedef struct packed {
        logic [16:0] block_bytes;
        logic [8:0]  line_count;
        logic [6:0]  bus_width;
        logic [9:0]  mem_read;
        logic [9:0]  mem_write;
        logic [9:0]  cache_read;
        logic [9:0]  cache_write;
    } t_cfg;

    typedef struct packed {
        logic                cmd;
        logic [TAG_BITS-1:0] blk;
        logic [IDX_W-1:0]    idx;
        logic [7:0]          transfers;
    } t_qent;

    typedef enum logic [1:0] {F_IDLE, F_DIV, F_MOD, F_PUSH} t_fstate;
    typedef enum logic [1:0] {B_IDLE, B_READ, B_CALC, B_DONE} t_bstate;

endpackage

@@ sv/dmc_front.sv @@
// ----------------------------------------------------------------------------
// dmc_front
// Accepts requests and derives block number, line index and transfer count
// with bit-serial restoring dividers.
// ----------------------------------------------------------------------------
module dmc_front import dmc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_push,
    input  logic        i_cmd,
    input  logic [31:0] i_address,
    input  logic [6:0]  i_byte_count,
    output logic        o_busy,
    input  logic        i_q_full,
    output logic        o_q_push,
    output t_qent       o_q_data
);

    t_fstate r_state, n_state;
    logic [4:0]  r_cnt;
    logic        r_cmd;
    logic [31:0] r_dvd, n_dvd;
    logic [16:0] r_rem, n_rem;
    logic [31:0] r_blk;
    logic [8:0]  r_mrem, n_mrem;
    logic [7:0]  r_tdvd, n_tdvd;
    logic [6:0]  r_trem, n_trem;

    logic [16:0] bsz;
    logic [8:0]  lines;
    logic [6:0]  width;
    logic [17:0] sh1;
    logic [9:0]  sh2;
    logic [7:0]  sht;

    assign bsz   = (i_cfg.block_bytes == 17'd0) ? 17'd1 : i_cfg.block_bytes;
    assign lines = (i_cfg.line_count == 9'd0) ? 9'd1 :
                   (i_cfg.line_count > 9'(MAX_LINES)) ? 9'(MAX_LINES) : i_cfg.line_count;
    assign width = (i_cfg.bus_width == 7'd0) ? 7'd1 : i_cfg.bus_width;

    // one quotient bit per cycle for each divider
    always_comb begin
        sh1    = {r_rem, r_dvd[31]};
        sh2    = {r_mrem, r_dvd[31]};
        sht    = {r_trem, r_tdvd[7]};
        n_dvd  = r_dvd;
        n_rem  = r_rem;
        n_mrem = r_mrem;
        n_tdvd = r_tdvd;
        n_trem = r_trem;
        if (r_state == F_DIV) begin
            if (sh1 >= {1'b0, bsz}) begin
                n_rem = 17'(sh1 - {1'b0, bsz});
                n_dvd = {r_dvd[30:0], 1'b1};
            end else begin
                n_rem = sh1[16:0];
                n_dvd = {r_dvd[30:0], 1'b0};
            end
            if (r_cnt < 5'd8) begin
                if (sht >= {1'b0, width}) begin
                    n_trem = 7'(sht - {1'b0, width});
                    n_tdvd = {r_tdvd[6:0], 1'b1};
                end else begin
                    n_trem = sht[6:0];
                    n_tdvd = {r_tdvd[6:0], 1'b0};
                end
            end
        end else if (r_state == F_MOD) begin
            n_dvd = {r_dvd[30:0], 1'b0};
            if (sh2 >= {1'b0, lines}) begin
                n_mrem = 9'(sh2 - {1'b0, lines});
            end else begin
                n_mrem = sh2[8:0];
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE: if (i_push) n_state = F_DIV;
            F_DIV:  if (r_cnt == 5'd31) n_state = F_MOD;
            F_MOD:  if (r_cnt == 5'd31) n_state = F_PUSH;
            F_PUSH: if (!i_q_full) n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    always_comb begin
        o_busy   = 1'b1;
        o_q_push = 1'b0;
        unique case (r_state)
            F_IDLE:  o_busy = 1'b0;
            F_PUSH:  o_q_push = !i_q_full;
            default: o_busy = 1'b1;
        endcase
    end

    assign o_q_data.cmd       = r_cmd;
    assign o_q_data.blk       = r_blk;
    assign o_q_data.idx       = r_mrem[IDX_W-1:0];
    assign o_q_data.transfers = r_tdvd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_cnt   <= 5'd0;
        end else begin
            r_state <= n_state;
            if (r_state == F_DIV || r_state == F_MOD) begin
                r_cnt <= r_cnt + 5'd1;
            end else begin
                r_cnt <= 5'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == F_IDLE && i_push) begin
            r_cmd  <= i_cmd;
            r_dvd  <= i_address;
            r_rem  <= 17'd0;
            r_mrem <= 9'd0;
            r_tdvd <= 8'({1'b0, i_byte_count} + {1'b0, width} - 8'd1);
            r_trem <= 7'd0;
        end else begin
            r_dvd  <= n_dvd;
            r_rem  <= n_rem;
            r_mrem <= n_mrem;
            r_tdvd <= n_tdvd;
            r_trem <= n_trem;
        end
        // hold the quotient as the block number before the modulo pass
        if (r_state == F_DIV && r_cnt == 5'd31) begin
            r_blk <= n_dvd;
        end
    end

endmodule

@@ sv/dmc_queue.sv @@
// ----------------------------------------------------------------------------
// dmc_queue
// Two-entry queue between the classifying front and the executing back.
// ----------------------------------------------------------------------------
`include "direct_mapped_cache_timing_model_unit_defines.svh"

module dmc_queue import dmc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_qent i_data,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_empty,
    output t_qent o_data
);

    t_qent      r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_count;
    logic       do_push, do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (do_push) r_wp <= !r_wp;
            if (do_pop)  r_rp <= !r_rp;
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wp] <= i_data;
    end

    `DMC_ASSERT_IMPL(a_count_max, i_clk, i_rst_n, 1'b1, r_count <= 2'd2, "queue overfilled")
    `DMC_ASSERT_NEXT(a_count_up, i_clk, i_rst_n, do_push && !do_pop, r_count == $past(r_count) + 2'd1, "push lost")
    `DMC_ASSERT_NEXT(a_count_dn, i_clk, i_rst_n, do_pop && !do_push, r_count == $past(r_count) - 2'd1, "pop lost")

endmodule

@@ sv/dmc_back.sv @@
// ----------------------------------------------------------------------------
// dmc_back
// Looks up the tag store, charges the access cost, updates the saturating
// totals and holds the result until it is taken.
// ----------------------------------------------------------------------------
module dmc_back import dmc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_q_empty,
    input  t_qent       i_q_data,
    output logic        o_q_pop,
    output logic        o_empty,
    input  logic        i_pop,
    output logic [1:0]  o_outcome,
    output logic [16:0] o_access_cost,
    output logic [47:0] o_total_clock,
    output logic [31:0] o_hit_total,
    output logic [31:0] o_read_total,
    output logic [31:0] o_write_total
);

    t_bstate r_state, n_state;
    t_qent   r_ent;
    logic [TAG_BITS-1:0] r_tagmem [MAX_LINES];
    logic [MAX_LINES-1:0] r_valid;
    logic [TAG_BITS-1:0] r_tag;
    logic        r_vld;
    logic        r_hit;
    logic [17:0] r_prod;
    logic [47:0] r_clock;
    logic [31:0] r_hits, r_reads, r_writes;
    logic        r_ov;

    logic        out_free, commit, fill;
    logic [17:0] cost18;
    logic [16:0] cost;
    logic [48:0] clk_sum;

    assign out_free = !r_ov || i_pop;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE: if (!i_q_empty) n_state = B_READ;
            B_READ: n_state = B_CALC;
            B_CALC: n_state = B_DONE;
            B_DONE: if (out_free) n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    always_comb begin
        o_q_pop = 1'b0;
        commit  = 1'b0;
        unique case (r_state)
            B_IDLE:  o_q_pop = !i_q_empty;
            B_DONE:  commit = out_free;
            default: commit = 1'b0;
        endcase
    end

    always_comb begin
        cost18 = 18'(r_prod) + ((r_vld || r_hit) ? 18'(i_cfg.cache_read) : 18'd0);
        if (r_hit) begin
            cost18 = 18'(i_cfg.cache_read);
        end else if (r_ent.cmd == CMD_READ) begin
            cost18 = cost18 + 18'(i_cfg.cache_write);
        end
        cost    = cost18[17] ? 17'h1FFFF : cost18[16:0];
        clk_sum = {1'b0, r_clock} + 49'(cost);
        fill    = commit && !r_hit && (r_ent.cmd == CMD_READ);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_valid  <= '0;
            r_clock  <= 48'd0;
            r_hits   <= 32'd0;
            r_reads  <= 32'd0;
            r_writes <= 32'd0;
            r_ov     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (fill) r_valid[r_ent.idx] <= 1'b1;
            if (commit) begin
                r_ov    <= 1'b1;
                r_clock <= clk_sum[48] ? 48'hFFFF_FFFF_FFFF : clk_sum[47:0];
                if (r_hit && r_hits != 32'hFFFF_FFFF) r_hits <= r_hits + 32'd1;
                if (r_ent.cmd == CMD_WRITE) begin
                    if (r_writes != 32'hFFFF_FFFF) r_writes <= r_writes + 32'd1;
                end else begin
                    if (r_reads != 32'hFFFF_FFFF) r_reads <= r_reads + 32'd1;
                end
            end else if (i_pop) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) r_ent <= i_q_data;
        if (r_state == B_READ) begin
            r_tag <= r_tagmem[r_ent.idx];
            r_vld <= r_valid[r_ent.idx];
        end
        if (r_state == B_CALC) begin
            r_hit  <= r_vld && (r_tag == r_ent.blk);
            r_prod <= 18'((r_ent.cmd == CMD_WRITE) ? i_cfg.mem_write : i_cfg.mem_read)
                      * 18'(r_ent.transfers);
        end
        if (fill) r_tagmem[r_ent.idx] <= r_ent.blk;
        if (commit) begin
            o_outcome     <= r_hit ? OUT_HIT : (r_vld ? OUT_MISMATCH : OUT_EMPTY);
            o_access_cost <= cost;
        end
    end

    assign o_empty       = !r_ov;
    assign o_total_clock = r_clock;
    assign o_hit_total   = r_hits;
    assign o_read_total  = r_reads;
    assign o_write_total = r_writes;

endmodule

@@ sv/direct_mapped_cache_timing_model_unit.sv @@
// ----------------------------------------------------------------------------
// direct_mapped_cache_timing_model_unit
// Timing model of a direct-mapped write-through, no-write-allocate cache.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter through a queue-like port: push with cmd, address and
//   byte_count; a request is taken at a clock edge with push high and full
//   low. Results leave through a queue-like port: while empty is low the
//   oldest result (outcome, access_cost and the running totals) is on the
//   o_ ports; pop high at such an edge takes it.
//   Configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx at
//   once; write only while no request is in flight.
// Timing:
//   The front runs the block-number division (the transfer count divides
//   alongside), then the line modulo, then hands off to the queue; full
//   stays high from each accept until the queue takes the request, so a new
//   request is taken only once the last one is handed off: that serial
//   divider sets throughput.
//   The back steps through queue pop, tag read, cost multiply and commit.
// Reset:
//   Synchronous, active low; valid bits, totals and registers clear to
//   their defaults, the tag store keeps its contents.
// Stall:
//   A result not popped stays put; the back holds its next request, the
//   two-entry queue fills and the front holds its finished request, with
//   full high, until the queue has room.
// ----------------------------------------------------------------------------
module direct_mapped_cache_timing_model_unit import dmc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [16:0] i_cfg_data,
    input  logic        push,
    output logic        full,
    input  logic        i_cmd,
    input  logic [31:0] i_address,
    input  logic [6:0]  i_byte_count,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  o_outcome,
    output logic [16:0] o_access_cost,
    output logic [47:0] o_total_clock,
    output logic [31:0] o_hit_total,
    output logic [31:0] o_read_total,
    output logic [31:0] o_write_total
);

    t_cfg  r_cfg;
    logic  q_push, q_full, q_pop, q_empty;
    t_qent q_wdata, q_rdata;

    // register file: take each write directly, ignore unknown indexes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.block_bytes <= 17'd16;
            r_cfg.line_count  <= 9'd64;
            r_cfg.bus_width   <= 7'd4;
            r_cfg.mem_read    <= 10'd10;
            r_cfg.mem_write   <= 10'd10;
            r_cfg.cache_read  <= 10'd1;
            r_cfg.cache_write <= 10'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_BLOCK_BYTES: r_cfg.block_bytes <= i_cfg_data;
                REG_LINE_COUNT:  r_cfg.line_count  <= i_cfg_data[8:0];
                REG_BUS_WIDTH:   r_cfg.bus_width   <= i_cfg_data[6:0];
                REG_MEM_READ:    r_cfg.mem_read    <= i_cfg_data[9:0];
                REG_MEM_WRITE:   r_cfg.mem_write   <= i_cfg_data[9:0];
                REG_CACHE_READ:  r_cfg.cache_read  <= i_cfg_data[9:0];
                REG_CACHE_WRITE: r_cfg.cache_write <= i_cfg_data[9:0];
                default:         r_cfg <= r_cfg;
            endcase
        end
    end

    // front: accept and classify
    dmc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_push       (push),
        .i_cmd        (i_cmd),
        .i_address    (i_address),
        .i_byte_count (i_byte_count),
        .o_busy       (full),
        .i_q_full     (q_full),
        .o_q_push     (q_push),
        .o_q_data     (q_wdata)
    );

    // decouple the two halves
    dmc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_rdata)
    );

    // back: look up, charge, count
    dmc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_q_empty     (q_empty),
        .i_q_data      (q_rdata),
        .o_q_pop       (q_pop),
        .o_empty       (empty),
        .i_pop         (pop),
        .o_outcome     (o_outcome),
        .o_access_cost (o_access_cost),
        .o_total_clock (o_total_clock),
        .o_hit_total   (o_hit_total),
        .o_read_total  (o_read_total),
        .o_write_total (o_write_total)
    );

endmodule

@@ sim/cache_cost_checker.sv @@
// ----------------------------------------------------------------------------
// cache_cost_checker
// Watches the request, result and register ports of the cache timing model,
// predicts outcome, cost and running totals, and compares each result.
// ----------------------------------------------------------------------------
module cache_cost_checker import dmc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [16:0] i_cfg_data,
    input  logic        push,
    input  logic        full,
    input  logic        i_cmd,
    input  logic [31:0] i_address,
    input  logic [6:0]  i_byte_count,
    input  logic        empty,
    input  logic        pop,
    input  logic [1:0]  i_outcome,
    input  logic [16:0] i_access_cost,
    input  logic [47:0] i_total_clock,
    input  logic [31:0] i_hit_total,
    input  logic [31:0] i_read_total,
    input  logic [31:0] i_write_total,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct {
        logic [1:0]  outcome;
        logic [16:0] cost;
        logic [47:0] clock;
        logic [31:0] hits;
        logic [31:0] reads;
        logic [31:0] writes;
    } t_access_result;

    t_cfg           model_cfg;
    logic           line_valid [MAX_LINES];
    logic [31:0]    line_tag [MAX_LINES];
    logic [47:0]    clock_sum;
    logic [31:0]    hit_sum;
    logic [31:0]    read_sum;
    logic [31:0]    write_sum;
    t_access_result access_q [$];

    function automatic t_access_result predict_access(logic c, logic [31:0] addr,
                                                      logic [6:0] nbytes);
        longint unsigned bsz, lines, width, blk, idx, xfers, cost;
        t_access_result  r;
        bsz   = (model_cfg.block_bytes == 0) ? 1 : model_cfg.block_bytes;
        lines = (model_cfg.line_count == 0) ? 1 : model_cfg.line_count;
        if (lines > MAX_LINES) lines = MAX_LINES;
        width = (model_cfg.bus_width == 0) ? 1 : model_cfg.bus_width;
        blk   = addr / bsz;
        idx   = blk % lines;
        xfers = (nbytes + width - 1) / width;
        if (!line_valid[idx] || line_tag[idx] != blk[31:0]) begin
            r.outcome = line_valid[idx] ? OUT_MISMATCH : OUT_EMPTY;
            cost = line_valid[idx] ? model_cfg.cache_read : 0;
            if (c == CMD_WRITE) begin
                cost += model_cfg.mem_write * xfers;    // no allocate on write
            end else begin
                line_valid[idx] = 1'b1;
                line_tag[idx]   = blk[31:0];
                cost += model_cfg.mem_read * xfers + model_cfg.cache_write;
            end
        end else begin
            r.outcome = OUT_HIT;
            cost = model_cfg.cache_read;
            if (hit_sum != '1) hit_sum++;
        end
        if (cost > 64'h1FFFF) cost = 64'h1FFFF;
        if (64'hFFFF_FFFF_FFFF - clock_sum < cost) clock_sum = '1;
        else clock_sum += cost[47:0];
        if (c == CMD_WRITE) begin
            if (write_sum != '1) write_sum++;
        end else begin
            if (read_sum != '1) read_sum++;
        end
        r.cost   = cost[16:0];
        r.clock  = clock_sum;
        r.hits   = hit_sum;
        r.reads  = read_sum;
        r.writes = write_sum;
        return r;
    endfunction

    task automatic check_field(string name, longint unsigned exp, longint unsigned act);
        if (exp != act) begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp, act);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_access_result exp;
        if (!i_rst_n) begin
            model_cfg = '{block_bytes: 17'd16, line_count: 9'd64, bus_width: 7'd4,
                          mem_read: 10'd10, mem_write: 10'd10, cache_read: 10'd1,
                          cache_write: 10'd1};
            foreach (line_valid[i]) line_valid[i] = 1'b0;
            clock_sum = '0;
            hit_sum   = '0;
            read_sum  = '0;
            write_sum = '0;
            o_fail_count = 0;
            access_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_BLOCK_BYTES: model_cfg.block_bytes = i_cfg_data;
                    REG_LINE_COUNT:  model_cfg.line_count  = i_cfg_data[8:0];
                    REG_BUS_WIDTH:   model_cfg.bus_width   = i_cfg_data[6:0];
                    REG_MEM_READ:    model_cfg.mem_read    = i_cfg_data[9:0];
                    REG_MEM_WRITE:   model_cfg.mem_write   = i_cfg_data[9:0];
                    REG_CACHE_READ:  model_cfg.cache_read  = i_cfg_data[9:0];
                    REG_CACHE_WRITE: model_cfg.cache_write = i_cfg_data[9:0];
                    default: ;
                endcase
            end
            // compare before enqueueing so a result can never match its own request
            if (pop && !empty) begin
                if (access_q.size() == 0) begin
                    $error("result popped with no request outstanding");
                    o_fail_count++;
                end else begin
                    exp = access_q.pop_front();
                    check_field("outcome", exp.outcome, i_outcome);
                    check_field("access_cost", exp.cost, i_access_cost);
                    check_field("total_clock", exp.clock, i_total_clock);
                    check_field("hit_total", exp.hits, i_hit_total);
                    check_field("read_total", exp.reads, i_read_total);
                    check_field("write_total", exp.writes, i_write_total);
                end
            end
            if (push && !full)
                access_q.push_back(predict_access(i_cmd, i_address, i_byte_count));
        end
        o_pending <= access_q.size();
    end

endmodule

@@ sim/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Drives the cache timing model through directed and random accesses under
// several register settings, with random idling on both queue ports and one
// long result hold-off; the checker beside the block judges every result.
// ----------------------------------------------------------------------------
module tb_top;
    import dmc_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int DRAIN_WAIT  = 100;   // extra settling time after the last result is popped

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = '0;
    logic [16:0] i_cfg_data = '0;
    logic        push = 1'b0;
    logic        full;
    logic        i_cmd = CMD_READ;
    logic [31:0] i_address = '0;
    logic [6:0]  i_byte_count = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [1:0]  o_outcome;
    logic [16:0] o_access_cost;
    logic [47:0] o_total_clock;
    logic [31:0] o_hit_total;
    logic [31:0] o_read_total;
    logic [31:0] o_write_total;

    int          fail_count;
    int          pending;
    int          cycle_count = 0;
    int          hold_cycles = 0;
    bit          hold_trigger = 1'b0;
    bit          steady = 1'b0;     // no idling on either side while set
    logic [31:0] recent_addr = '0;

    always #2 i_clk = ~i_clk;

    direct_mapped_cache_timing_model_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .push(push), .full(full),
        .i_cmd(i_cmd), .i_address(i_address), .i_byte_count(i_byte_count),
        .empty(empty), .pop(pop),
        .o_outcome(o_outcome), .o_access_cost(o_access_cost),
        .o_total_clock(o_total_clock), .o_hit_total(o_hit_total),
        .o_read_total(o_read_total), .o_write_total(o_write_total)
    );

    cache_cost_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .push(push), .full(full),
        .i_cmd(i_cmd), .i_address(i_address), .i_byte_count(i_byte_count),
        .empty(empty), .pop(pop),
        .i_outcome(o_outcome), .i_access_cost(o_access_cost),
        .i_total_clock(o_total_clock), .i_hit_total(o_hit_total),
        .i_read_total(o_read_total), .i_write_total(o_write_total),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // Watchdog: a hung handshake ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Result side: pop at random, or hold off entirely for a long stretch
    // so the block backs up and raises full.
    always @(posedge i_clk) begin
        if (hold_trigger) begin
            hold_trigger = 1'b0;
            hold_cycles  = 600;
        end
        if (hold_cycles > 0) begin
            hold_cycles = hold_cycles - 1;
            pop <= 1'b0;
        end else begin
            pop <= steady || ($urandom_range(99) >= 28);
        end
    end

    // Offer one request and hold it until accepted; push stays high on exit
    // so back-to-back requests never drop it within a step.
    task automatic send_request(logic c, logic [31:0] addr, logic [6:0] nbytes);
        while (!steady && $urandom_range(99) < 28) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push         <= 1'b1;
        i_cmd        <= c;
        i_address    <= addr;
        i_byte_count <= nbytes;
        recent_addr   = addr;
        do @(posedge i_clk); while (full);
    endtask

    // Let every outstanding request drain, then give the back end time to
    // go quiet before touching the registers.
    task automatic wait_idle();
        push <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_regs(logic [16:0] bsz, logic [16:0] lines, logic [16:0] width,
                              logic [16:0] mrd, logic [16:0] mwr,
                              logic [16:0] crd, logic [16:0] cwr);
        logic [16:0] vals [7];
        logic [2:0]  idx_list [7];
        vals     = '{bsz, lines, width, mrd, mwr, crd, cwr};
        idx_list = '{REG_BLOCK_BYTES, REG_LINE_COUNT, REG_BUS_WIDTH, REG_MEM_READ,
                     REG_MEM_WRITE, REG_CACHE_READ, REG_CACHE_WRITE};
        wait_idle();
        for (int i = 0; i < 7; i++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= idx_list[i];
            i_cfg_data <= vals[i];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    // Mostly clustered addresses so lines hit and collide; the rest reuse
    // the last address or are fully random.
    task automatic random_requests(int count);
        int          r;
        logic [31:0] addr;
        logic [6:0]  nbytes;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(99);
            if (r < 55)      addr = ($urandom_range(3) << 12) | $urandom_range(2047);
            else if (r < 70) addr = recent_addr;
            else             addr = $urandom;
            r = $urandom_range(99);
            nbytes = (r < 85) ? 7'($urandom_range(64, 1)) : 7'($urandom_range(127));
            send_request(1'($urandom_range(1)), addr, nbytes);
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset registers: empty fill, hits on read and write, mismatch write
        // that leaves the line, mismatch read that replaces it, zero size,
        // largest sizes and address extremes.
        send_request(CMD_READ,  32'h0000_0000, 7'd4);
        send_request(CMD_READ,  32'h0000_0004, 7'd1);
        send_request(CMD_WRITE, 32'h0000_0008, 7'd64);
        send_request(CMD_WRITE, 32'h0000_0400, 7'd5);
        send_request(CMD_READ,  32'h0000_0400, 7'd0);
        send_request(CMD_READ,  32'h0000_0000, 7'd127);
        send_request(CMD_WRITE, 32'h0000_0010, 7'd3);
        send_request(CMD_READ,  32'hFFFF_FFFF, 7'd64);
        send_request(CMD_READ,  32'hFFFF_FFF0, 7'd2);
        send_request(CMD_WRITE, 32'hFFFF_FFFF, 7'd127);
        send_request(CMD_WRITE, 32'hAAAA_AAAA, 7'd85);
        send_request(CMD_READ,  32'h5555_5555, 7'd42);

        // Default values, with the long hold-off partway through.
        write_regs(17'd16, 17'd64, 17'd4, 17'd10, 17'd10, 17'd1, 17'd1);
        random_requests(30);
        hold_trigger = 1'b1;
        random_requests(170);

        // Zero sizes act as one; maximum costs push access_cost into saturation.
        write_regs(17'd0, 17'd0, 17'd0, 17'd1023, 17'd1023, 17'd1023, 17'd1023);
        send_request(CMD_READ,  32'h0000_0000, 7'd127);
        send_request(CMD_READ,  32'h0000_0001, 7'd127);
        send_request(CMD_WRITE, 32'h0000_0002, 7'd127);
        send_request(CMD_READ,  32'h0000_0001, 7'd0);
        random_requests(150);

        // Largest register values, zero costs, no idling on either side.
        steady = 1'b1;
        write_regs(17'h1FFFF, 17'h1FF, 17'h7F, 17'd0, 17'd0, 17'd0, 17'd0);
        random_requests(150);
        steady = 1'b0;

        write_regs(17'd65536, 17'd256, 17'd64, 17'd1023, 17'd0, 17'd512, 17'd3);
        random_requests(200);
        write_regs(17'd1, 17'd1, 17'd1, 17'd7, 17'd9, 17'd2, 17'd5);
        random_requests(150);
        write_regs(17'd4, 17'd300, 17'd8, 17'd33, 17'd17, 17'd4, 17'd6);
        random_requests(200);
        write_regs(17'(1 << $urandom_range(16)), 17'($urandom_range(511)),
                   17'($urandom_range(127)), 17'($urandom_range(1023)),
                   17'($urandom_range(1023)), 17'($urandom_range(1023)),
                   17'($urandom_range(1023)));
        random_requests(150);

        wait_idle();
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+sv
sv/dmc_pkg.sv
sv/dmc_front.sv
sv/dmc_queue.sv
sv/dmc_back.sv
sv/direct_mapped_cache_timing_model_unit.sv
sim/cache_cost_checker.sv
sim/tb_top.sv
